[sv/heightmap_vertex_normal_core_macros.svh]
// ----------------------------------------------------------------------------
// heightmap vertex normal assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMAL_CORE_MACROS_SVH
`define HEIGHTMAP_VERTEX_NORMAL_CORE_MACROS_SVH

// same-cycle implication
`define HVN_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/hvn_pkg.sv]
// ----------------------------------------------------------------------------
// hvn_pkg
// shared constants and types of the heightmap vertex normal core
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MAX_COLS_DEF         = 256;
  localparam int MAX_ROWS_DEF         = 256;
  localparam int NORMAL_FRAC_BITS_DEF = 15;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_GRID_COLS = 1'b0;
  localparam logic REG_GRID_ROWS = 1'b1;

  localparam int         CFG_W      = 9;
  localparam logic [8:0] GRID_RESET = 9'd256;

  localparam int FIFO_DEPTH = 2;

  // height * 512 + 5, then divided by ten via reciprocal
  localparam int          HEIGHT_DIV        = 5;
  localparam int          SCALE_RECIP_SHIFT = 22;
  localparam logic [18:0] SCALE_RECIP       = 19'd419431;

  typedef struct packed {
    logic       op;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] height;
    logic       has_a;
    logic       has_b;
  } hvn_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } hvn_norm_stat_t;

endpackage

[sv/hvn_front.sv]
// ----------------------------------------------------------------------------
// hvn_front
// grid size registers, input acceptance and item classification
// ----------------------------------------------------------------------------
module hvn_front #(
  parameter int MAX_COLS = hvn_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = hvn_pkg::MAX_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [8:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_op_i,
  input  logic [7:0]        in_col_i,
  input  logic [7:0]        in_row_i,
  input  logic [7:0]        in_height_i,
  input  logic              full_i,
  output logic              push_o,
  output hvn_pkg::hvn_item_t item_o
);
  import hvn_pkg::*;

  localparam int CLW = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
  localparam int RLW = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;

  logic [CFG_W-1:0] cols_q, cols_d, rows_q, rows_d;
  logic [CLW-1:0]   cols_use, col_x;
  logic [RLW-1:0]   rows_use, row_x;
  logic             in_range;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_COLS: cols_d = cfg_data_i;
        REG_GRID_ROWS: rows_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= GRID_RESET;
      rows_q <= GRID_RESET;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  // grid size in use is clamped to [2, max]
  always_comb begin
    if (cols_q < CFG_W'(2))                     cols_use = CLW'(2);
    else if (CLW'(cols_q) > CLW'(MAX_COLS))     cols_use = CLW'(MAX_COLS);
    else                                        cols_use = CLW'(cols_q);
    if (rows_q < CFG_W'(2))                     rows_use = RLW'(2);
    else if (RLW'(rows_q) > RLW'(MAX_ROWS))     rows_use = RLW'(MAX_ROWS);
    else                                        rows_use = RLW'(rows_q);
  end

  assign col_x    = CLW'(in_col_i);
  assign row_x    = RLW'(in_row_i);
  assign in_range = (col_x < cols_use) && (row_x < rows_use);

  assign item_o.op     = in_op_i;
  assign item_o.col    = in_col_i;
  assign item_o.row    = in_row_i;
  assign item_o.height = in_height_i;
  assign item_o.has_a  = (in_col_i != 8'd0) && (in_row_i != 8'd0);
  assign item_o.has_b  = ((col_x + CLW'(1)) < cols_use) && ((row_x + RLW'(1)) < rows_use);

  // out-of-grid items are taken and dropped
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && in_range;

endmodule

[sv/hvn_fifo.sv]
// ----------------------------------------------------------------------------
// hvn_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_core_macros.svh"

module hvn_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hvn_pkg::hvn_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output hvn_pkg::hvn_item_t item_o
);
  import hvn_pkg::*;

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  hvn_item_t      slot_q [FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CW'(FIFO_DEPTH));
  assign empty_o = (count_q == CW'(0));
  assign item_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(FIFO_DEPTH - 1)) ? PW'(0) : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? PW'(0) : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i)      count_d = count_q + CW'(1);
    else if (pop_i && !push_i) count_d = count_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  `HVN_ASSERT(a_no_push_full, push_i, !full_o, "push into full queue")
  `HVN_ASSERT(a_no_pop_empty, pop_i, !empty_o, "pop from empty queue")
  `HVN_ASSERT_NEXT(a_push_fills, push_i && !pop_i, !empty_o, "queue empty after push")

endmodule

[sv/hvn_norm.sv]
// ----------------------------------------------------------------------------
// hvn_norm
// iterative unit-vector unit: exact rounded |v_k| * 2^F / |v| per component
// ----------------------------------------------------------------------------
module hvn_norm #(
  parameter int NORMAL_FRAC_BITS = hvn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [NORMAL_FRAC_BITS+2:0] vec_i [3],
  output hvn_pkg::hvn_norm_stat_t       stat_o,
  output logic signed [NORMAL_FRAC_BITS+1:0] res_o [3]
);
  import hvn_pkg::*;

  localparam int F          = NORMAL_FRAC_BITS;
  localparam int VW         = F + 3;
  localparam int MW         = F + 2;
  localparam int TW         = 2 * F + 4;
  localparam int SDW        = 2 * F + 4;
  localparam int RW         = F + 2;
  localparam int DIV_STEPS  = 2 * F + 2;
  localparam int SQRT_STEPS = F + 2;
  localparam int STW        = $clog2(DIV_STEPS + 1);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SQ    = 3'd1;
  localparam logic [2:0] N_MUL   = 3'd2;
  localparam logic [2:0] N_DINIT = 3'd3;
  localparam logic [2:0] N_DIV   = 3'd4;
  localparam logic [2:0] N_SQRT  = 3'd5;
  localparam logic [2:0] N_FIN   = 3'd6;

  logic [2:0]            st_q, st_d;
  logic [1:0]            k_q, k_d;
  logic [STW-1:0]        step_q, step_d;
  logic signed [VW-1:0]  v_q [3];
  logic signed [VW-1:0]  v_d [3];
  logic [MW-1:0]         mag_q [3];
  logic [MW-1:0]         mag_d [3];
  logic [TW-1:0]         tot_q, tot_d, mag2_q, mag2_d, rem_q, rem_d;
  logic [SDW-1:0]        quo_q, quo_d;
  logic [RW-1:0]         root_q, root_d;
  logic [RW:0]           srem_q, srem_d;
  logic signed [F+1:0]   res_q [3];
  logic signed [F+1:0]   res_d [3];

  logic [TW-1:0]         sq;
  logic [TW:0]           rem2, rem_sub;
  logic                  dge, sge;
  logic [RW+2:0]         cur, trial, cdiff;
  logic [RW:0]           lo;
  logic signed [F+1:0]   lo_s;
  logic                  done;

  assign sq      = TW'(mag_q[k_q]) * TW'(mag_q[k_q]);
  assign rem2    = {rem_q, 1'b0};
  assign rem_sub = rem2 - {1'b0, tot_q};
  assign dge     = rem2 >= {1'b0, tot_q};
  // restoring square root, two radicand bits per step
  assign cur     = {srem_q, quo_q[SDW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign cdiff   = cur - trial;
  assign sge     = cur >= trial;
  // round half up: largest m with (2m-1)^2 <= radicand
  assign lo      = ({1'b0, root_q} + (RW+1)'(1)) >> 1;
  assign lo_s    = $signed((F+2)'(lo));

  always_comb begin
    st_d   = st_q;
    k_d    = k_q;
    step_d = step_q;
    v_d    = v_q;
    mag_d  = mag_q;
    tot_d  = tot_q;
    mag2_d = mag2_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    root_d = root_q;
    srem_d = srem_q;
    res_d  = res_q;
    done   = 1'b0;
    unique case (st_q)
      N_IDLE: begin
        if (start_i) begin
          for (int i = 0; i < 3; i++) begin
            v_d[i]   = vec_i[i];
            mag_d[i] = (vec_i[i] < 0) ? MW'(-vec_i[i]) : MW'(vec_i[i]);
          end
          tot_d = '0;
          k_d   = 2'd0;
          st_d  = N_SQ;
        end
      end
      N_SQ: begin
        tot_d = tot_q + sq;
        if (k_q == 2'd2) begin
          k_d  = 2'd0;
          st_d = N_MUL;
        end else begin
          k_d = k_q + 2'd1;
        end
      end
      N_MUL: begin
        mag2_d = sq;
        st_d   = N_DINIT;
      end
      N_DINIT: begin
        if (mag2_q >= tot_q) begin
          rem_d = mag2_q - tot_q;
          quo_d = SDW'(1);
        end else begin
          rem_d = mag2_q;
          quo_d = '0;
        end
        step_d = '0;
        st_d   = N_DIV;
      end
      N_DIV: begin
        rem_d  = dge ? TW'(rem_sub) : TW'(rem2);
        quo_d  = {quo_q[SDW-2:0], dge};
        step_d = step_q + STW'(1);
        if (step_q == STW'(DIV_STEPS - 1)) begin
          step_d = '0;
          root_d = '0;
          srem_d = '0;
          st_d   = N_SQRT;
        end
      end
      N_SQRT: begin
        srem_d = sge ? (RW+1)'(cdiff) : (RW+1)'(cur);
        root_d = {root_q[RW-2:0], sge};
        quo_d  = {quo_q[SDW-3:0], 2'b00};
        step_d = step_q + STW'(1);
        if (step_q == STW'(SQRT_STEPS - 1)) begin
          st_d = N_FIN;
        end
      end
      N_FIN: begin
        if (tot_q == '0)       res_d[k_q] = '0;
        else if (v_q[k_q] < 0) res_d[k_q] = -lo_s;
        else                   res_d[k_q] = lo_s;
        if (k_q == 2'd2) begin
          k_d  = 2'd0;
          done = 1'b1;
          st_d = N_IDLE;
        end else begin
          k_d  = k_q + 2'd1;
          st_d = N_MUL;
        end
      end
      default: st_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      k_q    <= '0;
      step_q <= '0;
    end else begin
      st_q   <= st_d;
      k_q    <= k_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    mag_q  <= mag_d;
    tot_q  <= tot_d;
    mag2_q <= mag2_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    root_q <= root_d;
    srem_q <= srem_d;
    res_q  <= res_d;
  end

  assign stat_o.busy = (st_q != N_IDLE);
  assign stat_o.done = done;
  assign res_o       = res_d;

endmodule

[sv/hvn_back.sv]
// ----------------------------------------------------------------------------
// hvn_back
// height store, neighbour reads, normal sequencing and result register
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_core_macros.svh"

module hvn_back #(
  parameter int MAX_COLS         = hvn_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS         = hvn_pkg::MAX_ROWS_DEF,
  parameter int NORMAL_FRAC_BITS = hvn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  hvn_pkg::hvn_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [13:0]        out_height_scaled_o,
  output logic signed [15:0] out_normal_x_o,
  output logic signed [15:0] out_normal_y_o,
  output logic signed [15:0] out_normal_z_o
);
  import hvn_pkg::*;

  localparam int F     = NORMAL_FRAC_BITS;
  localparam int VW    = F + 3;
  localparam int OW    = (F + 2 > 16) ? F + 2 : 16;
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_READ    = 4'd1;
  localparam logic [3:0] S_START_A = 4'd2;
  localparam logic [3:0] S_WAIT_A  = 4'd3;
  localparam logic [3:0] S_START_B = 4'd4;
  localparam logic [3:0] S_WAIT_B  = 4'd5;
  localparam logic [3:0] S_CHECK   = 4'd6;
  localparam logic [3:0] S_START_S = 4'd7;
  localparam logic [3:0] S_WAIT_S  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  localparam logic signed [F+1:0] SAT_HI  = {2'b00, {F{1'b1}}};
  localparam logic signed [F+1:0] UNIT_UP = {2'b01, {F{1'b0}}};

  function automatic logic [AW-1:0] addr_of(input logic [8:0] c, input logic [8:0] r);
    logic [31:0] a;
    a = 32'(r) * 32'(MAX_COLS) + 32'(c);
    return a[AW-1:0];
  endfunction

  logic [7:0]            mem [DEPTH];
  logic [7:0]            rdata_q;
  logic                  mem_we;
  logic [AW-1:0]         mem_addr;

  logic [3:0]            state_q, state_d;
  logic [2:0]            rd_cnt_q, rd_cnt_d;
  hvn_item_t             item_q;
  logic [7:0]            he_q, hca_q, hda_q, hcb_q, hdb_q;
  logic signed [VW-1:0]  sum_q [3];
  logic signed [VW-1:0]  sum_d [3];
  logic signed [F+1:0]   fin_q [3];
  logic signed [F+1:0]   fin_d [3];

  logic                  out_valid_q, out_valid_d;
  logic [13:0]           hs_q, hs_d;
  logic signed [15:0]    nx_q, ny_q, nz_q;
  logic signed [15:0]    nrm_d [3];

  logic                  norm_start;
  hvn_norm_stat_t        norm_stat;
  logic signed [VW-1:0]  norm_vec [3];
  logic signed [F+1:0]   norm_res [3];
  logic signed [VW-1:0]  vec_a [3];
  logic signed [VW-1:0]  vec_b [3];
  logic signed [9:0]     pa, qa, pb, qb;

  logic [16:0]           hs_num;
  logic [35:0]           hs_prod;
  logic                  out_free;
  logic [8:0]            c0, r0;

  assign c0 = {1'b0, item_q.col};
  assign r0 = {1'b0, item_q.row};

  // load is written when it leaves the queue, reads come from item_q
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = addr_of(c0, r0);
    if (state_q == S_IDLE) begin
      mem_we   = !empty_i && (item_i.op == OP_LOAD);
      mem_addr = addr_of({1'b0, item_i.col}, {1'b0, item_i.row});
    end else begin
      case (rd_cnt_q)
        3'd1: if (item_q.has_a) mem_addr = addr_of(c0, r0 - 9'd1);
        3'd2: if (item_q.has_a) mem_addr = addr_of(c0 - 9'd1, r0);
        3'd3: if (item_q.has_b) mem_addr = addr_of(c0, r0 + 9'd1);
        3'd4: if (item_q.has_b) mem_addr = addr_of(c0 + 9'd1, r0);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= item_i.height;
    end
    rdata_q <= mem[mem_addr];
  end

  // triangle vectors, heights taken as height / 5
  assign pa = $signed({2'b00, he_q}) - $signed({2'b00, hca_q});
  assign qa = $signed({2'b00, hda_q}) - $signed({2'b00, hca_q});
  assign pb = $signed({2'b00, he_q}) - $signed({2'b00, hcb_q});
  assign qb = $signed({2'b00, hdb_q}) - $signed({2'b00, hcb_q});

  assign vec_a[0] = VW'(pa - qa);
  assign vec_a[1] = -VW'(HEIGHT_DIV);
  assign vec_a[2] = VW'(pa);
  assign vec_b[0] = VW'(qb - pb);
  assign vec_b[1] = -VW'(HEIGHT_DIV);
  assign vec_b[2] = -VW'(pb);

  assign norm_start = (state_q == S_START_A) || (state_q == S_START_B)
                   || (state_q == S_START_S);
  assign norm_vec   = (state_q == S_START_S) ? sum_q :
                      (state_q == S_START_B) ? vec_b : vec_a;

  hvn_norm #(
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(norm_start),
    .vec_i  (norm_vec),
    .stat_o (norm_stat),
    .res_o  (norm_res)
  );

  // round(he * 256 / 5) = floor((he * 512 + 5) / 10)
  assign hs_num  = {he_q, 9'd0} + 17'(HEIGHT_DIV);
  assign hs_prod = 36'(hs_num) * 36'(SCALE_RECIP);

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    logic signed [F+1:0] sat;
    logic signed [OW-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      sat     = (fin_q[i] > SAT_HI) ? SAT_HI : fin_q[i];
      ext     = OW'(sat);
      nrm_d[i] = ext[15:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    sum_d       = sum_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    hs_d        = hs_prod[SCALE_RECIP_SHIFT +: 14];
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i && (item_i.op == OP_QUERY)) begin
          rd_cnt_d = '0;
          for (int i = 0; i < 3; i++) sum_d[i] = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == 3'd5) begin
          rd_cnt_d = '0;
          if (item_q.has_a)      state_d = S_START_A;
          else if (item_q.has_b) state_d = S_START_B;
          else                   state_d = S_CHECK;
        end
      end
      S_START_A: state_d = S_WAIT_A;
      S_WAIT_A: begin
        if (norm_stat.done) begin
          for (int i = 0; i < 3; i++) sum_d[i] = sum_q[i] + VW'(norm_res[i]);
          state_d = item_q.has_b ? S_START_B : S_CHECK;
        end
      end
      S_START_B: state_d = S_WAIT_B;
      S_WAIT_B: begin
        if (norm_stat.done) begin
          for (int i = 0; i < 3; i++) sum_d[i] = sum_q[i] + VW'(norm_res[i]);
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if ((sum_q[0] == '0) && (sum_q[1] == '0) && (sum_q[2] == '0)) begin
          // no triangle: straight up
          fin_d[0] = '0;
          fin_d[1] = UNIT_UP;
          fin_d[2] = '0;
          state_d  = S_DONE;
        end else begin
          state_d = S_START_S;
        end
      end
      S_START_S: state_d = S_WAIT_S;
      S_WAIT_S: begin
        if (norm_stat.done) begin
          fin_d   = norm_res;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= item_i;
    if (state_q == S_READ) begin
      case (rd_cnt_q)
        3'd1: he_q  <= rdata_q;
        3'd2: hca_q <= rdata_q;
        3'd3: hda_q <= rdata_q;
        3'd4: hcb_q <= rdata_q;
        3'd5: hdb_q <= rdata_q;
        default: ;
      endcase
    end
    sum_q <= sum_d;
    fin_q <= fin_d;
    if ((state_q == S_DONE) && out_free) begin
      hs_q <= hs_d;
      nx_q <= nrm_d[0];
      ny_q <= nrm_d[1];
      nz_q <= nrm_d[2];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_height_scaled_o = hs_q;
  assign out_normal_x_o      = nx_q;
  assign out_normal_y_o      = ny_q;
  assign out_normal_z_o      = nz_q;

  `HVN_ASSERT(a_norm_start_idle, norm_start, !norm_stat.busy, "normalize started while busy")
  `HVN_ASSERT(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE), "result without query")
  `HVN_ASSERT(a_tri_a_present, state_q == S_START_A, item_q.has_a, "triangle a without neighbours")

endmodule

[sv/heightmap_vertex_normal_core.sv]
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_core
// height grid store with per-vertex scaled height and unit normal queries
// ----------------------------------------------------------------------------
// channel  | direction | handshake               | payload
// cfg      | in        | cfg_we_i                | cfg_idx_i, cfg_data_i
// in       | in        | in_valid_i / in_stall_o | op, col, row, height
// out      | out       | out_valid_o/out_stall_i | height_scaled, normal_x/y/z
//
// an off-grid item is dropped at the front; a load is written to the height
// store as it leaves the queue; a query reads five heights, then runs up to
// three normalizations on one shared unit
// a two-entry queue lets the front accept while the back works, until full
// the result register holds while it is valid and out_stall_i is high;
// the back goes on until its next result is ready and then waits
// reset clears control state only; the height store is not cleared
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_core #(
  parameter int MAX_COLS         = hvn_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS         = hvn_pkg::MAX_ROWS_DEF,
  parameter int NORMAL_FRAC_BITS = hvn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_op_i,
  input  logic [7:0]         in_col_i,
  input  logic [7:0]         in_row_i,
  input  logic [7:0]         in_height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [13:0]        out_height_scaled_o,
  output logic signed [15:0] out_normal_x_o,
  output logic signed [15:0] out_normal_y_o,
  output logic signed [15:0] out_normal_z_o
);
  import hvn_pkg::*;

  hvn_item_t push_item, pop_item;
  logic      push, pop, full, empty;

  hvn_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_op_i    (in_op_i),
    .in_col_i   (in_col_i),
    .in_row_i   (in_row_i),
    .in_height_i(in_height_i),
    .full_i     (full),
    .push_o     (push),
    .item_o     (push_item)
  );

  hvn_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (pop_item)
  );

  hvn_back #(
    .MAX_COLS        (MAX_COLS),
    .MAX_ROWS        (MAX_ROWS),
    .NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .empty_i            (empty),
    .item_i             (pop_item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_height_scaled_o(out_height_scaled_o),
    .out_normal_x_o     (out_normal_x_o),
    .out_normal_y_o     (out_normal_y_o),
    .out_normal_z_o     (out_normal_z_o)
  );

endmodule
